// ----- rtl/sptg_pkg.sv -----
// Shared types and constants for the sparse table range gcd block.
package sptg_pkg;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_NUM_LEVELS   = 11;
    localparam int VAL_W            = 31;
    localparam int IDX_W            = 10;
    localparam int LEN_W            = IDX_W + 1;
    localparam int K_W              = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_Q_CHECK,
        ST_Q_RDA,
        ST_Q_RDB,
        ST_Q_GSTART,
        ST_Q_GCD,
        ST_Q_FIN,
        ST_B_LEVEL,
        ST_B_RDA,
        ST_B_RDB,
        ST_B_GSTART,
        ST_B_GCD
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_QA,
        RD_QB,
        RD_BA,
        RD_BB
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    store;
        rd_sel_t rd_sel;
        logic    latch_a;
        logic    gcd_start;
        logic    out_load;
        logic    b_init;
        logic    b_write;
        logic    b_next_level;
        logic    b_done;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic last;
        logic q_err;
        logic gcd_done;
        logic lvl_ok;
        logic next_idx_ok;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/sptg_gcd.sv -----
// Iterative binary gcd unit, one reduction step per cycle.
module sptg_gcd
    import sptg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] a_in,
    input  logic [VAL_W-1:0] b_in,
    output logic             done,
    output logic [VAL_W-1:0] result
);

    logic [VAL_W-1:0] a_reg, a_next;
    logic [VAL_W-1:0] b_reg, b_next;
    logic [4:0]       sh_reg, sh_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [VAL_W-1:0] res_reg, res_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        sh_next   = sh_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start)
        begin
            a_next   = a_in;
            b_next   = b_in;
            sh_next  = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            priority if (a_reg == '0 || b_reg == '0)
            begin
                res_next  = VAL_W'((a_reg | b_reg) << sh_reg);
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next  = a_reg >> 1;
                b_next  = b_reg >> 1;
                sh_next = sh_reg + 5'd1;
            end
            else if (!a_reg[0])
                a_next = a_reg >> 1;
            else if (!b_reg[0])
                b_next = b_reg >> 1;
            else if (a_reg >= b_reg)
                a_next = (a_reg - b_reg) >> 1;
            else
                b_next = (b_reg - a_reg) >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        sh_reg  <= sh_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- rtl/sptg_datapath.sv -----
// Datapath: item capture, level table memory, build counters, gcd unit, output register.
module sptg_datapath
    import sptg_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int NUM_LEVELS   = DEF_NUM_LEVELS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output stat_t            stat,
    input  logic             in_func,
    input  logic [VAL_W-1:0] in_value,
    input  logic             in_last,
    input  logic [IDX_W-1:0] in_left,
    input  logic [IDX_W-1:0] in_right,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [VAL_W-1:0] out_gcd,
    output logic             out_err
);

    localparam int IW        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW        = $clog2(MAX_ELEMENTS + 1);
    localparam int LW        = $clog2(NUM_LEVELS);
    localparam int LVW       = $clog2(NUM_LEVELS + 1);
    localparam int AW        = LW + IW;
    localparam int MEM_DEPTH = NUM_LEVELS * (2 ** IW);

    logic [VAL_W-1:0] mem [0:MEM_DEPTH-1];

    logic             func_reg;
    logic [VAL_W-1:0] value_reg;
    logic             last_reg;
    logic [IDX_W-1:0] left_reg, right_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             ready_reg, ready_next;
    logic [LVW-1:0]   lvl_reg, lvl_next;
    logic [CW:0]      span_reg, span_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [VAL_W-1:0] rd_data_reg;
    logic [VAL_W-1:0] opa_reg;
    logic             ovalid_reg, ovalid_next;
    logic [VAL_W-1:0] ogcd_reg;
    logic             oerr_reg;

    logic [LEN_W-1:0] q_len;
    logic [K_W-1:0]   q_k;
    logic             q_err;
    logic [IDX_W-1:0] q_start2;
    logic [CW-1:0]    store_idx;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             rd_en, wr_en;
    logic [VAL_W-1:0] wr_data;
    logic             gcd_done;
    logic [VAL_W-1:0] gcd_result;
    logic [CW:0]      half;

    always_comb
    begin
        q_len = LEN_W'(right_reg) - LEN_W'(left_reg) + LEN_W'(1);
        q_k   = '0;
        for (int b = 0; b < LEN_W; b++)
        begin
            if (q_len[b])
                q_k = K_W'(b);
        end
        q_err = !ready_reg || (left_reg > right_reg)
              || (32'(right_reg) >= 32'(count_reg)) || (32'(q_k) >= NUM_LEVELS);
        q_start2 = IDX_W'(LEN_W'(right_reg) + LEN_W'(1) - (LEN_W'(1) << q_k));
    end

    assign half      = span_reg >> 1;
    assign store_idx = ready_reg ? '0 : count_reg;

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        unique case (cmd.rd_sel)
            RD_QA:   rd_addr = {LW'(q_k), IW'(left_reg)};
            RD_QB:   rd_addr = {LW'(q_k), IW'(q_start2)};
            RD_BA:   rd_addr = {LW'(lvl_reg - LVW'(1)), IW'(i_reg)};
            RD_BB:   rd_addr = {LW'(lvl_reg - LVW'(1)), IW'((CW+1)'(i_reg) + half)};
            default: rd_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {LW'(lvl_reg), IW'(i_reg)};
        wr_data = gcd_result;
        if (cmd.store && (32'(store_idx) < MAX_ELEMENTS))
        begin
            wr_en   = 1'b1;
            wr_addr = {LW'(0), IW'(store_idx)};
            wr_data = value_reg;
        end
        else if (cmd.b_write)
            wr_en = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    sptg_gcd u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.gcd_start),
        .a_in   (opa_reg),
        .b_in   (rd_data_reg),
        .done   (gcd_done),
        .result (gcd_result)
    );

    always_comb
    begin
        count_next  = count_reg;
        ready_next  = ready_reg;
        lvl_next    = lvl_reg;
        span_next   = span_reg;
        i_next      = i_reg;
        ovalid_next = ovalid_reg && !out_ready;
        if (cmd.store)
        begin
            ready_next = 1'b0;
            count_next = (32'(store_idx) < MAX_ELEMENTS) ? store_idx + CW'(1) : store_idx;
        end
        if (cmd.b_init)
        begin
            lvl_next  = LVW'(1);
            span_next = (CW+1)'(2);
        end
        if (cmd.b_write)
            i_next = i_reg + CW'(1);
        if (cmd.b_next_level)
        begin
            lvl_next  = lvl_reg + LVW'(1);
            span_next = span_reg << 1;
        end
        if (cmd.b_init || cmd.b_next_level)
            i_next = '0;
        if (cmd.b_done)
            ready_next = 1'b1;
        if (cmd.out_load)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ready_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ready_reg  <= ready_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg  <= lvl_next;
        span_reg <= span_next;
        i_reg    <= i_next;
        if (cmd.capture)
        begin
            func_reg  <= in_func;
            value_reg <= in_value;
            last_reg  <= in_last;
            left_reg  <= in_left;
            right_reg <= in_right;
        end
        if (cmd.latch_a)
            opa_reg <= rd_data_reg;
        if (cmd.out_load)
        begin
            ogcd_reg <= q_err ? '0 : gcd_result;
            oerr_reg <= q_err;
        end
    end

    always_comb
    begin
        stat.is_query    = func_reg;
        stat.last        = last_reg;
        stat.q_err       = q_err;
        stat.gcd_done    = gcd_done;
        stat.lvl_ok      = (32'(lvl_reg) < NUM_LEVELS) && (span_reg <= (CW+1)'(count_reg));
        stat.next_idx_ok = ((CW+1)'(i_reg) + (CW+1)'(1) + span_reg) <= (CW+1)'(count_reg);
        stat.out_free    = !ovalid_reg || out_ready;
    end

    assign out_valid = ovalid_reg;
    assign out_gcd   = ogcd_reg;
    assign out_err   = oerr_reg;

endmodule

// ----- rtl/sptg_ctrl.sv -----
// Controller state machine sequencing loads, queries and the table build.
module sptg_ctrl
    import sptg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_Q_CHECK;
            end
            ST_Q_CHECK:
            begin
                if (!stat.is_query)
                    state_next = ST_LOAD;
                else if (stat.q_err)
                    state_next = ST_Q_FIN;
                else
                    state_next = ST_Q_RDA;
            end
            ST_LOAD:
            begin
                cmd.store  = 1'b1;
                cmd.b_init = stat.last;
                state_next = stat.last ? ST_B_LEVEL : ST_IDLE;
            end
            ST_Q_RDA:
            begin
                cmd.rd_sel = RD_QA;
                state_next = ST_Q_RDB;
            end
            ST_Q_RDB:
            begin
                cmd.rd_sel  = RD_QB;
                cmd.latch_a = 1'b1;
                state_next  = ST_Q_GSTART;
            end
            ST_Q_GSTART:
            begin
                cmd.gcd_start = 1'b1;
                state_next    = ST_Q_GCD;
            end
            ST_Q_GCD:
            begin
                if (stat.gcd_done)
                    state_next = ST_Q_FIN;
            end
            ST_Q_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_B_LEVEL:
            begin
                if (stat.lvl_ok)
                    state_next = ST_B_RDA;
                else
                begin
                    cmd.b_done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_B_RDA:
            begin
                cmd.rd_sel = RD_BA;
                state_next = ST_B_RDB;
            end
            ST_B_RDB:
            begin
                cmd.rd_sel  = RD_BB;
                cmd.latch_a = 1'b1;
                state_next  = ST_B_GSTART;
            end
            ST_B_GSTART:
            begin
                cmd.gcd_start = 1'b1;
                state_next    = ST_B_GCD;
            end
            ST_B_GCD:
            begin
                if (stat.gcd_done)
                begin
                    cmd.b_write = 1'b1;
                    if (stat.next_idx_ok)
                        state_next = ST_B_RDA;
                    else
                    begin
                        cmd.b_next_level = 1'b1;
                        state_next       = ST_B_LEVEL;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/sparse_table_range_gcd.sv -----
// Top level of the sparse table range gcd block.
// One transaction at a time. A query reads two level table entries and runs the gcd unit on them;
// an error query skips the reads and the gcd. The load marked last then runs the build: for
// every level j and start index i with i + 2^j <= count, two reads of level j-1 and one gcd
// per entry, during which no transaction is accepted. The level table memory has one read
// and one write port, and the binary gcd unit takes one reduction step per cycle. A finished
// result waits in the output register while the next transaction is accepted. The table needs
// no clearing pass: queries only read entries the build wrote.
module sparse_table_range_gcd
    import sptg_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int NUM_LEVELS   = DEF_NUM_LEVELS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // value[30:0], left_index[40:31], right_index[50:41], zeros
    input  logic        s_tlast,   // last_element
    input  logic        s_tuser,   // func: 0 load, 1 query
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // range_gcd[30:0], zero
    output logic        m_tuser    // query_error
);

    cmd_t             cmd;
    stat_t            stat;
    logic [VAL_W-1:0] out_gcd;

    sptg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sptg_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .NUM_LEVELS   (NUM_LEVELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_func   (s_tuser),
        .in_value  (s_tdata[30:0]),
        .in_last   (s_tlast),
        .in_left   (s_tdata[40:31]),
        .in_right  (s_tdata[50:41]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_gcd   (out_gcd),
        .out_err   (m_tuser)
    );

    assign m_tdata = {1'b0, out_gcd};

`ifndef NO_ASSERTIONS
    // result only loaded when the output register is free
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // one transaction at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a transaction while busy");

    // loads never produce a result
    a_store_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (!cmd.out_load && !stat.is_query))
        else $error("load produced a result");
`endif

endmodule
